[rtl/core/hall_quadrature_pll_macros.svh]
// assertion helpers shared by the tracker core
`ifndef HALL_QUADRATURE_PLL_MACROS_SVH
`define HALL_QUADRATURE_PLL_MACROS_SVH
`ifndef NO_ASSERTIONS
`define HQP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define HQP_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define HQP_ASSERT(lbl, prop, msg)
`define HQP_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

[rtl/core/hqp_pkg.sv]
package hqp_pkg;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [16:0] GAIN_ONE    = 17'd65536;

    localparam logic [30:0] PROP_GAIN_RST  = 31'd34178264;
    localparam logic [30:0] INTEG_GAIN_RST = 31'd437482;
    localparam logic [16:0] ERR_GAIN_RST   = 17'd15668;
    localparam logic [16:0] SPD_GAIN_RST   = 17'd813;

    localparam logic [1:0] REG_PROP_GAIN  = 2'd0;
    localparam logic [1:0] REG_INTEG_GAIN = 2'd1;
    localparam logic [1:0] REG_ERR_GAIN   = 2'd2;
    localparam logic [1:0] REG_SPD_GAIN   = 2'd3;

    // one datapath step per code, issued by the sequencer
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_SIN,
        OP_COS,
        OP_MUL_A,
        OP_MUL_B,
        OP_FILT_A,
        OP_FILT_B,
        OP_UPD_B,
        OP_ERR,
        OP_KI,
        OP_KP,
        OP_SPD,
        OP_FS,
        OP_DONE,
        OP_OUT
    } hqp_op_t;

    typedef struct packed {
        hqp_op_t op;
        logic    rom_cos;
    } hqp_cmd_t;

endpackage

[rtl/core/hqp_if.sv]
interface hqp_in_if #(parameter int SAMPLE_WIDTH = 16);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_a;
    logic signed [SAMPLE_WIDTH-1:0] sample_b;

    modport source (output valid, sample_a, sample_b, input ready);
    modport sink (input valid, sample_a, sample_b, output ready);
endinterface

interface hqp_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] angle;
    logic signed [31:0] speed;
    logic signed [31:0] filtered_speed;

    modport source (output valid, angle, speed, filtered_speed, input ready);
    modport sink (input valid, angle, speed, filtered_speed, output ready);
endinterface

[rtl/core/hall_quadrature_pll.sv]
// Angle tracker for two linear Hall sensors in quadrature. Each request on samples carries
// one pair of Q1.15 readings; the block correlates them with sine and cosine of its tracked
// 32-bit phase, lowpass filters the two products, runs a PI loop with a saturating
// integrator and returns one result per request: the new angle (top 16 bits of the phase),
// the speed as phase increment per sample and a slow-filtered speed. Between acceptance
// and the result register, a sequencer walks one shared 33x32 multiplier through the
// seven products of the loop and reads the single-port sine table twice. The result sits
// in an output register, so the next request is taken as soon as the sequencer is back
// in idle, in the cycle after the result is loaded; samples are handled one at a time, and
// the sequencer only waits if the previous result is still held. Gains are to be written
// over the APB port only while no sample is in flight; the block does not enforce this.
module hall_quadrature_pll
    import hqp_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int SAMPLE_WIDTH     = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    hqp_in_if.sink      samples,
    hqp_out_if.source   results,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [30:0] prop_gain_reg;
    logic [30:0] integ_gain_reg;
    logic [16:0] err_gain_reg;
    logic [16:0] spd_gain_reg;

    logic        reg_write;
    logic [1:0]  reg_index;
    logic        out_free;
    hqp_cmd_t    cmd;

    assign pready    = 1'b1;
    assign reg_write = psel && penable && pwrite;
    assign reg_index = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg  <= PROP_GAIN_RST;
            integ_gain_reg <= INTEG_GAIN_RST;
            err_gain_reg   <= ERR_GAIN_RST;
            spd_gain_reg   <= SPD_GAIN_RST;
        end
        else if (reg_write)
        begin
            case (reg_index)
                REG_PROP_GAIN:  prop_gain_reg  <= pwdata[30:0];
                REG_INTEG_GAIN: integ_gain_reg <= pwdata[30:0];
                REG_ERR_GAIN:   err_gain_reg   <= pwdata[16:0];
                REG_SPD_GAIN:   spd_gain_reg   <= pwdata[16:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_PROP_GAIN:  prdata = {1'b0, prop_gain_reg};
            REG_INTEG_GAIN: prdata = {1'b0, integ_gain_reg};
            REG_ERR_GAIN:   prdata = {15'd0, err_gain_reg};
            REG_SPD_GAIN:   prdata = {15'd0, spd_gain_reg};
            default:        prdata = '0;
        endcase
    end

    hqp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (samples.ready),
        .out_free (out_free),
        .cmd      (cmd)
    );

    hqp_dp #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .SAMPLE_WIDTH     (SAMPLE_WIDTH)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sample_a          (samples.sample_a),
        .sample_b          (samples.sample_b),
        .prop_gain         (prop_gain_reg),
        .integ_gain        (integ_gain_reg),
        .error_filter_gain (err_gain_reg),
        .speed_filter_gain (spd_gain_reg),
        .out_ready         (results.ready),
        .out_free          (out_free),
        .out_valid         (results.valid),
        .angle             (results.angle),
        .speed             (results.speed),
        .filtered_speed    (results.filtered_speed)
    );

endmodule

[rtl/core/hqp_sine_rom.sv]
module hqp_sine_rom
    import hqp_pkg::*;
#(
    parameter int DEPTH = 1024
)
(
    input  logic                             clk,
    input  logic [$clog2(DEPTH + 1)-1:0]     addr,
    output logic [14:0]                      data
);

    // quarter-wave sine, Q30 taylor series to x^13, rounded to 32767 full scale
    function automatic logic [14:0] sine_entry(input int k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x    = (HALF_PI_Q30 * 64'(k)) / DEPTH;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        term = ((term * x2) >> 30) / 6;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = ((term * x2) >> 30) / 20;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 42;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = ((term * x2) >> 30) / 72;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 110;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = ((term * x2) >> 30) / 156;
        sum  = sum + term;
        sum  = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
        if (sum > 64'd32767)
        begin
            sum = 64'd32767;
        end
        return sum[14:0];
    endfunction

    logic [14:0] rom_mem [DEPTH + 1];
    logic [14:0] data_reg;

    for (genvar k = 0; k <= DEPTH; k++)
    begin : gen_entry
        localparam logic [14:0] ENTRY = sine_entry(k);
        assign rom_mem[k] = ENTRY;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= rom_mem[addr];
    end

    assign data = data_reg;

endmodule

[rtl/core/hqp_dp.sv]
`include "hall_quadrature_pll_macros.svh"

module hqp_dp
    import hqp_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int SAMPLE_WIDTH     = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  hqp_cmd_t                       cmd,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_a,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_b,
    input  logic [30:0]                    prop_gain,
    input  logic [30:0]                    integ_gain,
    input  logic [16:0]                    error_filter_gain,
    input  logic [16:0]                    speed_filter_gain,
    input  logic                           out_ready,
    output logic                           out_free,
    output logic                           out_valid,
    output logic signed [15:0]             angle,
    output logic signed [31:0]             speed,
    output logic signed [31:0]             filtered_speed
);

    localparam int AW = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int SW = 30 + AW;

    function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
        logic signed [31:0] r;
        if (v > 51'sd2147483647)
        begin
            r = 32'sh7fffffff;
        end
        else if (v < -51'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = 32'(v);
        end
        return r;
    endfunction

    // loop state
    logic [31:0]        phase_reg;
    logic signed [31:0] integ_reg;
    logic signed [31:0] fqa_reg;
    logic signed [31:0] fqb_reg;
    logic signed [31:0] fs_reg;

    // per-sample working registers
    logic signed [SAMPLE_WIDTH-1:0] a_reg;
    logic signed [SAMPLE_WIDTH-1:0] b_reg;
    logic signed [15:0]             s_reg;
    logic signed [15:0]             c_reg;
    logic signed [17:0]             qa_reg;
    logic signed [17:0]             qb_reg;
    logic signed [31:0]             err_reg;
    logic signed [31:0]             spd_reg;
    logic signed [64:0]             prod_reg;

    logic                           out_valid_reg;
    logic signed [15:0]             angle_reg;
    logic signed [31:0]             speed_reg;
    logic signed [31:0]             fspd_reg;

    logic [1:0]         quad_s;
    logic [1:0]         quad_c;
    logic [1:0]         quad_rd;
    logic [SW-1:0]      scaled;
    logic [AW-1:0]      idx;
    logic [AW-1:0]      rom_addr;
    logic [14:0]        rom_q;
    logic signed [15:0] rom_mag;

    logic [16:0]        ge_eff;
    logic [16:0]        gs_eff;
    logic signed [32:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [64:0] prod_next;
    logic signed [17:0] q_shift;
    logic signed [48:0] p_shift;
    logic signed [50:0] pi_sum;
    logic signed [32:0] err_sum;

    assign quad_s  = phase_reg[31:30];
    assign quad_c  = phase_reg[31:30] + 2'd1;
    assign quad_rd = cmd.rom_cos ? quad_c : quad_s;
    assign scaled  = SW'(phase_reg[29:0]) * SW'(SINE_TABLE_DEPTH);
    assign idx     = scaled[SW-1:30];
    // odd quadrants run the table backwards
    assign rom_addr = quad_rd[0] ? AW'(SINE_TABLE_DEPTH) - idx : idx;
    assign rom_mag  = $signed({1'b0, rom_q});

    hqp_sine_rom #(
        .DEPTH (SINE_TABLE_DEPTH)
    ) u_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_q)
    );

    assign ge_eff = (error_filter_gain > GAIN_ONE) ? GAIN_ONE : error_filter_gain;
    assign gs_eff = (speed_filter_gain > GAIN_ONE) ? GAIN_ONE : speed_filter_gain;

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_MUL_A:
            begin
                mul_a = 33'(a_reg);
                mul_b = 32'(c_reg);
            end
            OP_MUL_B:
            begin
                mul_a = 33'(b_reg);
                mul_b = 32'(s_reg);
            end
            OP_FILT_A:
            begin
                mul_a = 33'(qa_reg) - 33'(fqa_reg);
                mul_b = $signed({15'd0, ge_eff});
            end
            OP_FILT_B:
            begin
                mul_a = 33'(qb_reg) - 33'(fqb_reg);
                mul_b = $signed({15'd0, ge_eff});
            end
            OP_KI:
            begin
                mul_a = 33'(err_reg);
                mul_b = $signed({1'b0, integ_gain});
            end
            OP_KP:
            begin
                mul_a = 33'(err_reg);
                mul_b = $signed({1'b0, prop_gain});
            end
            OP_FS:
            begin
                mul_a = 33'(spd_reg) - 33'(fs_reg);
                mul_b = $signed({15'd0, gs_eff});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = 65'(mul_a) * 65'(mul_b);
    assign q_shift   = 18'(prod_reg >>> (SAMPLE_WIDTH - 2));
    assign p_shift   = 49'(prod_reg >>> 16);
    assign pi_sum    = 51'(integ_reg) + 51'(p_shift);
    assign err_sum   = 33'(fqa_reg) + 33'(fqb_reg);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        case (cmd.op)
            OP_CAPTURE:
            begin
                a_reg <= sample_a;
                b_reg <= sample_b;
            end
            OP_SIN:    s_reg   <= quad_s[1] ? -rom_mag : rom_mag;
            OP_COS:    c_reg   <= quad_c[1] ? -rom_mag : rom_mag;
            OP_MUL_B:  qa_reg  <= q_shift;
            OP_FILT_A: qb_reg  <= -q_shift;
            OP_ERR:    err_reg <= 32'(err_sum >>> 1);
            OP_SPD:    spd_reg <= sat32(pi_sum);
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            integ_reg <= '0;
            fqa_reg   <= '0;
            fqb_reg   <= '0;
            fs_reg    <= '0;
        end
        else
        begin
            case (cmd.op)
                OP_FILT_B: fqa_reg   <= fqa_reg + 32'(p_shift);
                OP_UPD_B:  fqb_reg   <= fqb_reg + 32'(p_shift);
                OP_KP:     integ_reg <= sat32(pi_sum);
                OP_FS:     phase_reg <= phase_reg + 32'(spd_reg);
                OP_DONE:   fs_reg    <= fs_reg + 32'(p_shift);
                default:
                begin
                end
            endcase
        end
    end

    // output register, frees the core while a result waits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.op == OP_OUT)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_OUT)
        begin
            angle_reg <= $signed(phase_reg[31:16]);
            speed_reg <= spd_reg;
            fspd_reg  <= fs_reg;
        end
    end

    assign out_free       = !out_valid_reg || out_ready;
    assign out_valid      = out_valid_reg;
    assign angle          = angle_reg;
    assign speed          = speed_reg;
    assign filtered_speed = fspd_reg;

    `HQP_ASSERT(a_no_overwrite, !(cmd.op == OP_OUT && out_valid_reg && !out_ready), "result overwritten")
    `HQP_ASSERT_NEXT(a_load_sets_valid, cmd.op == OP_OUT, out_valid_reg, "loaded result not valid")
    `HQP_ASSERT(a_rom_addr_range, rom_addr <= AW'(SINE_TABLE_DEPTH), "sine address past table")

endmodule

[rtl/core/hqp_ctrl.sv]
`include "hall_quadrature_pll_macros.svh"

module hqp_ctrl
    import hqp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  logic     out_free,
    output hqp_cmd_t cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SIN    = 4'd1;
    localparam logic [3:0] ST_COS    = 4'd2;
    localparam logic [3:0] ST_MUL_A  = 4'd3;
    localparam logic [3:0] ST_MUL_B  = 4'd4;
    localparam logic [3:0] ST_FILT_A = 4'd5;
    localparam logic [3:0] ST_FILT_B = 4'd6;
    localparam logic [3:0] ST_UPD_B  = 4'd7;
    localparam logic [3:0] ST_ERR    = 4'd8;
    localparam logic [3:0] ST_KI     = 4'd9;
    localparam logic [3:0] ST_KP     = 4'd10;
    localparam logic [3:0] ST_SPD    = 4'd11;
    localparam logic [3:0] ST_FS     = 4'd12;
    localparam logic [3:0] ST_DONE   = 4'd13;
    localparam logic [3:0] ST_OUT    = 4'd14;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cmd.op      = OP_NONE;
        cmd.rom_cos = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_CAPTURE;
                    state_next = ST_SIN;
                end
            end
            ST_SIN:
            begin
                cmd.op      = OP_SIN;
                cmd.rom_cos = 1'b1;
                state_next  = ST_COS;
            end
            ST_COS:
            begin
                cmd.op     = OP_COS;
                state_next = ST_MUL_A;
            end
            ST_MUL_A:
            begin
                cmd.op     = OP_MUL_A;
                state_next = ST_MUL_B;
            end
            ST_MUL_B:
            begin
                cmd.op     = OP_MUL_B;
                state_next = ST_FILT_A;
            end
            ST_FILT_A:
            begin
                cmd.op     = OP_FILT_A;
                state_next = ST_FILT_B;
            end
            ST_FILT_B:
            begin
                cmd.op     = OP_FILT_B;
                state_next = ST_UPD_B;
            end
            ST_UPD_B:
            begin
                cmd.op     = OP_UPD_B;
                state_next = ST_ERR;
            end
            ST_ERR:
            begin
                cmd.op     = OP_ERR;
                state_next = ST_KI;
            end
            ST_KI:
            begin
                cmd.op     = OP_KI;
                state_next = ST_KP;
            end
            ST_KP:
            begin
                cmd.op     = OP_KP;
                state_next = ST_SPD;
            end
            ST_SPD:
            begin
                cmd.op     = OP_SPD;
                state_next = ST_FS;
            end
            ST_FS:
            begin
                cmd.op     = OP_FS;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                cmd.op     = OP_DONE;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // wait here while the previous result is still held
                if (out_free)
                begin
                    cmd.op     = OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `HQP_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_reg == ST_SIN, "request did not start")
    `HQP_ASSERT_NEXT(a_out_stall_holds, state_reg == ST_OUT && !out_free, state_reg == ST_OUT, "left output step early")
    `HQP_ASSERT(a_state_legal, state_reg <= ST_OUT, "illegal sequencer state")

endmodule
